/* src/jobf_pkg.sv */
// Shared types and constants for the JSON object boundary framer.
`timescale 1ns / 1ps

package jobf_pkg;

  // Default bounds, handed to the top level as parameter defaults
  localparam longint unsigned MAX_TEXT_BYTES_DEFAULT = 64'd65536;
  localparam int unsigned     MAX_NESTING_DEFAULT    = 255;

  // Fixed widths of the result fields
  localparam int OFFSET_W = 16;
  localparam int LENGTH_W = 17;

  // Characters that steer the framer
  localparam logic [7:0] CH_OPEN   = 8'h7B;
  localparam logic [7:0] CH_CLOSE  = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // One input beat: a byte of text
  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_last;
  } text_beat_t;

  // One result beat per input byte
  typedef struct packed {
    logic                object_begins;
    logic                object_ends;
    logic [OFFSET_W-1:0] object_offset;
    logic [LENGTH_W-1:0] object_length;
    logic                depth_overflow;
  } result_beat_t;

endpackage

/* src/json_object_boundary_framer_top.sv */
// Top level of the JSON object boundary framer: input and result registers around the core.
`timescale 1ns / 1ps

// Takes one text byte per beat and returns one result beat per byte, flagging where a
// top-level JSON object opens and closes; at a close it gives the object's start offset and
// its length in bytes. Throughput is one byte per clock cycle while result_stall is low, set
// by the state update in the core; each accepted byte reaches its result through an input
// register and a result register. text_stall follows result_stall in the same cycle when
// both registers are full. Byte offsets wrap modulo MAX_TEXT_BYTES, nesting saturates at
// MAX_NESTING, and all state clears after a byte marked text_last.
module json_object_boundary_framer_top #(
  parameter longint unsigned MAX_TEXT_BYTES = jobf_pkg::MAX_TEXT_BYTES_DEFAULT,
  parameter int unsigned     MAX_NESTING    = jobf_pkg::MAX_NESTING_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   text_valid,
  output logic                   text_stall,
  input  jobf_pkg::text_beat_t   text,
  output logic                   result_valid,
  input  logic                   result_stall,
  output jobf_pkg::result_beat_t result
);

  logic                   in_valid;
  jobf_pkg::text_beat_t   in_beat;
  logic                   out_load;
  logic                   advance;
  jobf_pkg::result_beat_t core_result;

  assign out_load   = !result_valid || !result_stall;
  assign advance    = in_valid && out_load;
  assign text_stall = in_valid && !out_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!text_stall) begin
      in_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!text_stall && text_valid) begin
      in_beat <= text;
    end
  end

  jobf_core #(
    .MAX_TEXT_BYTES (MAX_TEXT_BYTES),
    .MAX_NESTING    (MAX_NESTING)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .text   (in_beat),
    .result (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_result;
    end
  end

endmodule

/* src/jobf_core.sv */
// Framer state and the per-byte decision logic.
`timescale 1ns / 1ps

module jobf_core #(
  parameter longint unsigned MAX_TEXT_BYTES = jobf_pkg::MAX_TEXT_BYTES_DEFAULT,
  parameter int unsigned     MAX_NESTING    = jobf_pkg::MAX_NESTING_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  jobf_pkg::text_beat_t   text,
  output jobf_pkg::result_beat_t result
);

  localparam int PW = (MAX_TEXT_BYTES > 64'd1) ? $clog2(MAX_TEXT_BYTES) : 1;
  localparam int DW = $clog2(MAX_NESTING + 1);
  localparam int OW = jobf_pkg::OFFSET_W;
  localparam int LW = jobf_pkg::LENGTH_W;
  localparam logic [PW-1:0] LAST_POS  = PW'(MAX_TEXT_BYTES - 64'd1);
  localparam logic [PW:0]   MODULUS   = (PW+1)'(MAX_TEXT_BYTES);
  localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_NESTING);

  logic [PW-1:0] pos, pos_next;
  logic [PW-1:0] start, start_next;
  logic [DW-1:0] depth, depth_next;
  logic          instr, instr_next;
  logic          esc, esc_next;

  logic          is_open, is_close, is_quote, is_bslash;
  logic [PW:0]   len_wide;

  assign is_open   = (text.text_byte == jobf_pkg::CH_OPEN);
  assign is_close  = (text.text_byte == jobf_pkg::CH_CLOSE);
  assign is_quote  = (text.text_byte == jobf_pkg::CH_QUOTE);
  assign is_bslash = (text.text_byte == jobf_pkg::CH_BSLASH);

  // Wrapped distance from the opening brace, inclusive of both ends
  always_comb begin
    if (pos >= start) begin
      len_wide = {1'b0, pos} - {1'b0, start} + (PW+1)'(1);
    end else begin
      len_wide = {1'b0, pos} + MODULUS - {1'b0, start} + (PW+1)'(1);
    end
  end

  // Per-byte decision
  always_comb begin
    depth_next = depth;
    start_next = start;
    instr_next = instr;
    esc_next   = esc;
    pos_next   = (pos == LAST_POS) ? '0 : pos + 1'b1;
    result     = '0;

    if (depth == '0) begin
      // outside any object only an opening brace matters
      if (is_open) begin
        depth_next           = DW'(1);
        start_next           = pos;
        instr_next           = 1'b0;
        esc_next             = 1'b0;
        result.object_begins = 1'b1;
      end
    end else if (instr) begin
      if (esc) begin
        esc_next = 1'b0;
      end else if (is_bslash) begin
        esc_next = 1'b1;
      end else if (is_quote) begin
        instr_next = 1'b0;
      end
    end else if (is_quote) begin
      instr_next = 1'b1;
    end else if (is_open) begin
      if (depth >= DEPTH_MAX) begin
        result.depth_overflow = 1'b1;
      end else begin
        depth_next = depth + 1'b1;
      end
    end else if (is_close) begin
      depth_next = depth - 1'b1;
      if (depth == DW'(1)) begin
        result.object_ends   = 1'b1;
        result.object_offset = OW'(start);
        result.object_length = LW'(len_wide);
      end
    end

    // last byte of a text wipes everything
    if (text.text_last) begin
      depth_next = '0;
      start_next = '0;
      instr_next = 1'b0;
      esc_next   = 1'b0;
      pos_next   = '0;
    end
  end

  // State registers, advanced once per byte handled
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      start <= '0;
      depth <= '0;
      instr <= 1'b0;
      esc   <= 1'b0;
    end else if (step) begin
      pos   <= pos_next;
      start <= start_next;
      depth <= depth_next;
      instr <= instr_next;
      esc   <= esc_next;
    end
  end

endmodule

/* src/jobf_checker.sv */
// Port-level checks for the framer top level, bound to it.
`timescale 1ns / 1ps

module jobf_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   text_valid,
  input logic                   text_stall,
  input jobf_pkg::text_beat_t   text,
  input logic                   result_valid,
  input logic                   result_stall,
  input jobf_pkg::result_beat_t result
);

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // input stalls only when the result side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> result_valid && result_stall)
    else $error("input stalled without result back-pressure");

  // an object cannot open and close on the same byte
  a_begin_end: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.object_begins && result.object_ends))
    else $error("begin and end on one byte");

  // overflow only on a nested brace, never on a boundary
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.depth_overflow |-> !result.object_begins && !result.object_ends)
    else $error("overflow flagged on an object boundary");

  // offset and length are zero away from an end
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.object_ends |->
      result.object_offset == '0 && result.object_length == '0)
    else $error("offset or length set without an end");

endmodule

bind json_object_boundary_framer_top jobf_checker u_jobf_checker (.*);
